// ===== hw/rtl/aabb_pkg.sv =====
// ----------------------------------------------------------------------------
// aabb_pkg: shared types and constants
// Command codes, the queued job record and field widths for the box core.
// ----------------------------------------------------------------------------
`default_nettype none

package aabb_pkg;

    localparam int unsigned COORD_W = 32;
    localparam int unsigned COEF_W  = 16;
    localparam int unsigned REG_W   = 64;
    localparam int unsigned IDX_W   = 2;

    typedef enum logic [1:0] {
        CMD_INSERT    = 2'd0,
        CMD_TRANSFORM = 2'd1,
        CMD_CLEAR     = 2'd2,
        CMD_NONE      = 2'd3
    } cmd_t;

    localparam logic [IDX_W-1:0] REG_COL_X = 2'd0;
    localparam logic [IDX_W-1:0] REG_COL_Y = 2'd1;
    localparam logic [IDX_W-1:0] REG_COL_Z = 2'd2;

    // snapshot of the box handed from the front to the transform engine
    typedef struct packed {
        logic signed [COORD_W-1:0] min_x;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] min_z;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] max_y;
        logic signed [COORD_W-1:0] max_z;
        logic                      filled;
    } box_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] min_x;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] min_z;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] max_y;
        logic signed [COORD_W-1:0] max_z;
        logic                      source_filled;
    } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/aabb_if.sv =====
// ----------------------------------------------------------------------------
// aabb channel interfaces
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface aabb_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [31:0] point_x;
    logic [31:0] point_y;
    logic [31:0] point_z;

    modport source (output valid, command, point_x, point_y, point_z, input ready);
    modport sink   (input valid, command, point_x, point_y, point_z, output ready);
endinterface

interface aabb_res_if;
    logic        valid;
    logic        ready;
    logic [31:0] out_min_x;
    logic [31:0] out_min_y;
    logic [31:0] out_min_z;
    logic [31:0] out_max_x;
    logic [31:0] out_max_y;
    logic [31:0] out_max_z;
    logic        source_filled;

    modport source (output valid, out_min_x, out_min_y, out_min_z, out_max_x,
                    out_max_y, out_max_z, source_filled, input ready);
    modport sink   (input valid, out_min_x, out_min_y, out_min_z, out_max_x,
                    out_max_y, out_max_z, source_filled, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/aabb_front.sv =====
// ----------------------------------------------------------------------------
// aabb_front: box accumulator
// Takes command beats, updates the box for insert and clear at one per cycle,
// and pushes a box snapshot into the job queue for each transform.
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    aabb_cmd_if.sink            cmd,
    output aabb_pkg::box_t      job,
    output logic                job_push,
    input  wire logic           job_full
);
    import aabb_pkg::*;

    box_t box_reg;
    box_t box_next;
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] pz;
    logic take;

    assign px = cmd.point_x;
    assign py = cmd.point_y;
    assign pz = cmd.point_z;

    // only a transform needs queue space
    assign cmd.ready = !(job_full && cmd_t'(cmd.command) == CMD_TRANSFORM);
    assign take      = cmd.valid && cmd.ready;
    assign job       = box_reg;
    assign job_push  = take && cmd_t'(cmd.command) == CMD_TRANSFORM;

    always_comb
    begin
        box_next = box_reg;
        if (take)
        begin
            unique case (cmd_t'(cmd.command))
                CMD_INSERT:
                begin
                    if (!box_reg.filled)
                    begin
                        box_next.min_x  = px;
                        box_next.max_x  = px;
                        box_next.min_y  = py;
                        box_next.max_y  = py;
                        box_next.min_z  = pz;
                        box_next.max_z  = pz;
                        box_next.filled = 1'b1;
                    end
                    else
                    begin
                        if (px < box_reg.min_x) box_next.min_x = px;
                        if (px > box_reg.max_x) box_next.max_x = px;
                        if (py < box_reg.min_y) box_next.min_y = py;
                        if (py > box_reg.max_y) box_next.max_y = py;
                        if (pz < box_reg.min_z) box_next.min_z = pz;
                        if (pz > box_reg.max_z) box_next.max_z = pz;
                    end
                end
                CMD_CLEAR:     box_next = '0;
                CMD_TRANSFORM: box_next = box_reg;
                default:       box_next = box_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            box_reg <= '0;
        else
            box_reg <= box_next;
    end

    a_box_order: assert property (@(posedge clk) disable iff (!rst_n)
        box_reg.filled |-> (box_reg.min_x <= box_reg.max_x
            && box_reg.min_y <= box_reg.max_y && box_reg.min_z <= box_reg.max_z))
        else $error("box corners out of order");
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !box_reg.filled |-> box_reg == '0)
        else $error("empty box not zero");
    a_push_ok: assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> !job_full)
        else $error("push into full queue");

endmodule

`default_nettype wire

// ===== hw/rtl/aabb_queue.sv =====
// ----------------------------------------------------------------------------
// aabb_queue: job queue
// Small register fifo of box snapshots between the front and the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire aabb_pkg::box_t push_data,
    input  wire logic           push,
    output logic                full,
    output aabb_pkg::box_t      pop_data,
    output logic                not_empty,
    input  wire logic           pop
);
    import aabb_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    box_t              mem_reg [DEPTH];
    logic [PW-1:0]     wp_reg;
    logic [PW-1:0]     rp_reg;
    logic [PW:0]       cnt_reg;

    assign full      = cnt_reg == (PW+1)'(DEPTH);
    assign not_empty = cnt_reg != '0;
    assign pop_data  = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= (wp_reg == PW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (pop)
                rp_reg <= (rp_reg == PW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (PW+1)'(push) - (PW+1)'(pop);
        end
    end

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from empty queue");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (PW+1)'(DEPTH))
        else $error("queue count overrun");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queue count missed a push");

endmodule

`default_nettype wire

// ===== hw/rtl/aabb_engine.sv =====
// ----------------------------------------------------------------------------
// aabb_engine: corner transform engine
// Walks the eight corners through three column datapaths (multiply, sum,
// round/saturate), folds min and max per axis, and holds the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_engine (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [aabb_pkg::REG_W-1:0] col_x,
    input  wire logic [aabb_pkg::REG_W-1:0] col_y,
    input  wire logic [aabb_pkg::REG_W-1:0] col_z,
    input  wire aabb_pkg::box_t             job,
    input  wire logic                       job_valid,
    output logic                            job_pop,
    aabb_res_if.source                      res
);
    import aabb_pkg::*;

    localparam int unsigned PROD_W = COORD_W + COEF_W;
    localparam int unsigned SUM_W  = PROD_W + 2;

    // stage 0: corner issue
    logic       busy_reg;
    logic [2:0] corner_reg;
    box_t       box_reg;
    // stage 1: products
    logic                       p1_valid_reg;
    logic                       p1_first_reg;
    logic                       p1_last_reg;
    logic signed [PROD_W-1:0]   prod_reg [3][3];
    logic signed [COEF_W-1:0]   trans_reg [3];
    // stage 2: saturated corner values
    logic                       p2_valid_reg;
    logic                       p2_first_reg;
    logic                       p2_last_reg;
    logic signed [COORD_W-1:0]  val_reg [3];
    // fold and result
    logic signed [COORD_W-1:0]  lo_reg [3];
    logic signed [COORD_W-1:0]  hi_reg [3];
    logic                       done_reg;
    logic                       filled_reg;
    logic                       res_valid_reg;
    result_t                    res_reg;

    logic [REG_W-1:0]           cols [3];
    logic signed [COORD_W-1:0]  cx;
    logic signed [COORD_W-1:0]  cy;
    logic signed [COORD_W-1:0]  cz;
    logic signed [COORD_W-1:0]  sat_v [3];
    logic signed [COORD_W-1:0]  lo_n [3];
    logic signed [COORD_W-1:0]  hi_n [3];
    logic                       issue;

    assign cols[0] = col_x;
    assign cols[1] = col_y;
    assign cols[2] = col_z;

    assign cx = corner_reg[0] ? box_reg.max_x : box_reg.min_x;
    assign cy = corner_reg[1] ? box_reg.max_y : box_reg.min_y;
    assign cz = corner_reg[2] ? box_reg.max_z : box_reg.min_z;

    // a new job starts only when the result slot will be free at the end
    assign issue   = !busy_reg && job_valid && !done_reg
                     && !p1_valid_reg && !p2_valid_reg;
    assign job_pop = issue;

    always_comb
    begin
        logic signed [SUM_W-1:0] s;
        logic signed [SUM_W-1:0] r;
        for (int a = 0; a < 3; a++)
        begin
            s = SUM_W'(prod_reg[a][0]) + SUM_W'(prod_reg[a][1])
                + SUM_W'(prod_reg[a][2])
                + SUM_W'($signed({trans_reg[a], 16'h0000})) + SUM_W'(128);
            r = s >>> 8;
            if (r > SUM_W'(32'sh7fffffff))
                sat_v[a] = 32'sh7fffffff;
            else if (r < -SUM_W'(33'sh080000000))
                sat_v[a] = 32'sh80000000;
            else
                sat_v[a] = r[COORD_W-1:0];
            lo_n[a] = (p2_first_reg || val_reg[a] < lo_reg[a]) ? val_reg[a] : lo_reg[a];
            hi_n[a] = (p2_first_reg || val_reg[a] > hi_reg[a]) ? val_reg[a] : hi_reg[a];
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
            box_reg <= job;
        for (int a = 0; a < 3; a++)
        begin
            prod_reg[a][0] <= cx * $signed(cols[a][15:0]);
            prod_reg[a][1] <= cy * $signed(cols[a][31:16]);
            prod_reg[a][2] <= cz * $signed(cols[a][47:32]);
            trans_reg[a]   <= cols[a][63:48];
            val_reg[a]     <= sat_v[a];
            if (p2_valid_reg)
            begin
                lo_reg[a] <= lo_n[a];
                hi_reg[a] <= hi_n[a];
            end
        end
        if (p2_valid_reg && p2_last_reg)
        begin
            res_reg.min_x         <= lo_n[0];
            res_reg.min_y         <= lo_n[1];
            res_reg.min_z         <= lo_n[2];
            res_reg.max_x         <= hi_n[0];
            res_reg.max_y         <= hi_n[1];
            res_reg.max_z         <= hi_n[2];
            res_reg.source_filled <= filled_reg;
        end
        if (issue)
            filled_reg <= job.filled;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            corner_reg    <= '0;
            p1_valid_reg  <= 1'b0;
            p1_first_reg  <= 1'b0;
            p1_last_reg   <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p2_first_reg  <= 1'b0;
            p2_last_reg   <= 1'b0;
            done_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (issue)
            begin
                busy_reg   <= 1'b1;
                corner_reg <= '0;
                done_reg   <= 1'b1;
            end
            else if (busy_reg)
            begin
                corner_reg <= corner_reg + 1'b1;
                if (corner_reg == 3'd7)
                    busy_reg <= 1'b0;
            end
            p1_valid_reg <= busy_reg;
            p1_first_reg <= corner_reg == 3'd0;
            p1_last_reg  <= corner_reg == 3'd7;
            p2_valid_reg <= p1_valid_reg;
            p2_first_reg <= p1_first_reg;
            p2_last_reg  <= p1_last_reg;
            if (p2_valid_reg && p2_last_reg)
                res_valid_reg <= 1'b1;
            else if (res.ready)
                res_valid_reg <= 1'b0;
            // slot busy from issue until the beat leaves
            if (res_valid_reg && res.ready && !issue)
                done_reg <= 1'b0;
        end
    end

    assign res.valid         = res_valid_reg;
    assign res.out_min_x     = res_reg.min_x;
    assign res.out_min_y     = res_reg.min_y;
    assign res.out_min_z     = res_reg.min_z;
    assign res.out_max_x     = res_reg.max_x;
    assign res.out_max_y     = res_reg.max_y;
    assign res.out_max_z     = res_reg.max_z;
    assign res.source_filled = res_reg.source_filled;

    a_issue_idle: assert property (@(posedge clk) disable iff (!rst_n)
        issue |-> !res_valid_reg)
        else $error("job issued over pending result");
    a_result_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(p2_valid_reg && p2_last_reg))
        else $error("result without full corner walk");
    a_done_cover: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg || p1_valid_reg || p2_valid_reg || res_valid_reg) |-> done_reg)
        else $error("slot flag dropped early");

endmodule

`default_nettype wire

// ===== hw/rtl/aabb_accumulate_and_transform_core.sv =====
// ----------------------------------------------------------------------------
// aabb_accumulate_and_transform_core: box accumulator with affine transform
// Keeps an axis-aligned box and emits its transformed bounds on request.
// ----------------------------------------------------------------------------
// Usage:
//   cmd channel: one beat per command (insert point, transform, clear).
//   Insert and clear beats are taken every cycle and update the box at once.
//   A transform beat snapshots the box into a job queue of QUEUE_DEPTH
//   entries; cmd stalls on a transform only while that queue is full.
//   res channel: one beat per transform, from a registered output slot.
//   A transform's result beat follows the queue, the corner issue and walk,
//   the product and saturation stages and the min/max fold into the slot.
//   The engine walks the eight corners one per cycle through three
//   multiply/round columns and a new job starts only once the previous
//   result beat has left, so one transform finishes before the next starts.
//   Inserts sustain one per cycle regardless of engine activity.
//   Config: cfg_we writes register cfg_index with cfg_data; write only
//   while idle. Reset empties the box, clears the coefficients and the queue.
//   A stalled receiver holds the result beat; queued jobs wait behind it.
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_accumulate_and_transform_core #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [aabb_pkg::IDX_W-1:0]   cfg_index,
    input  wire logic [aabb_pkg::REG_W-1:0]   cfg_data,
    aabb_cmd_if.sink                          cmd,
    aabb_res_if.source                        res
);
    import aabb_pkg::*;

    logic [REG_W-1:0] col_x_reg;
    logic [REG_W-1:0] col_y_reg;
    logic [REG_W-1:0] col_z_reg;
    box_t             push_data;
    box_t             pop_data;
    logic             push;
    logic             full;
    logic             not_empty;
    logic             pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_x_reg <= '0;
            col_y_reg <= '0;
            col_z_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_COL_X) col_x_reg <= cfg_data;
            if (cfg_index == REG_COL_Y) col_y_reg <= cfg_data;
            if (cfg_index == REG_COL_Z) col_z_reg <= cfg_data;
        end
    end

    aabb_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .job      (push_data),
        .job_push (push),
        .job_full (full)
    );

    aabb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_data (push_data),
        .push      (push),
        .full      (full),
        .pop_data  (pop_data),
        .not_empty (not_empty),
        .pop       (pop)
    );

    aabb_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .col_x     (col_x_reg),
        .col_y     (col_y_reg),
        .col_z     (col_z_reg),
        .job       (pop_data),
        .job_valid (not_empty),
        .job_pop   (pop),
        .res       (res)
    );

endmodule

`default_nettype wire
